FILE: rtl/core/vde_pkg.sv
// ----------------------------------------------------------------------------
// vde_pkg: shared constants and types for the vector distance engine
// Fraction width, metric codes and data widths.
// ----------------------------------------------------------------------------
package vde_pkg;
  localparam int unsigned FracBits = 8;
  localparam int unsigned DataW    = 16;
  localparam int unsigned AccW     = 32;

  typedef enum logic [2:0] {
    MET_MANHATTAN = 3'd0,
    MET_CHEBYSHEV = 3'd1,
    MET_EUCLIDEAN = 3'd2,
    MET_COSINE    = 3'd3,
    MET_BRAYCURT  = 3'd4,
    MET_CANBERRA  = 3'd5,
    MET_UNUSED6   = 3'd6,
    MET_UNUSED7   = 3'd7
  } metric_e;

  typedef struct packed {
    logic signed [DataW-1:0] x_value;
    logic signed [DataW-1:0] y_value;
    logic                    last_element;
  } in_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] distance;
    logic                    saturated;
  } out_item_t;
endpackage

FILE: rtl/core/vde_if.sv
// ----------------------------------------------------------------------------
// vde_in_if / vde_out_if: valid/ready channels of the distance engine
// One transfer when valid and ready are both high at a rising edge.
// ----------------------------------------------------------------------------
interface vde_in_if import vde_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface vde_out_if import vde_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/vector_distance_engine_top.sv
// ----------------------------------------------------------------------------
// vector_distance_engine_top: streaming fixed-point vector distance
// Accumulates element pairs and emits one distance per vector.
// ----------------------------------------------------------------------------
// Channels: in_ch carries one element pair (x_value, y_value, last_element)
// per transfer; out_ch carries one distance with its saturated flag per
// vector. The metric register is written through cfg_we_i/cfg_wdata_i; the
// user must do so only while the block is idle: the block does not enforce it.
// Timing: in_ch.ready is high only in idle. After a transfer the block is
// busy in S_MUL, S_ACC and S_FIN (Manhattan, Chebyshev, Euclidean,
// Bray-Curtis, unused codes); cosine loops S_MUL, S_ACC for three products,
// Canberra puts a 64-step restoring divide between them (skipping it and
// S_ACC when both elements are zero). A last pair then runs 32 root steps
// for Euclidean, 64 divide steps for Bray-Curtis, or two roots, a product
// and a divide for cosine, then posts its result from S_OUT; a zero total,
// norm or norm product skips what follows. One 33x33 multiplier serves all products.
// Reset clears the metric (Manhattan), all sums and the output register.
// The result sits in an output register and holds while the receiver
// stalls; the next vector is taken meanwhile, and its result waits in the
// final state until that register is free.
// ----------------------------------------------------------------------------
module vector_distance_engine_top
  import vde_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_wdata_i,
  vde_in_if.sink     in_ch,
  vde_out_if.source  out_ch
);
  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_ACC, S_DIV, S_SQRT, S_FIN, S_COS_SY, S_COS_DEN,
    S_COS_DIV, S_OUT
  } state_e;

  localparam logic [31:0] U32Max = 32'hFFFF_FFFF;
  localparam logic [63:0] One    = 64'd1 << FracBits;

  state_e            state_q;
  metric_e           metric_q;
  logic [AccW-1:0]   prim_q, nx_q, ny_q;
  logic signed [16:0] x_q, y_q;
  logic              last_q;
  logic [1:0]        mstep_q;        // product index within a pair
  logic signed [63:0] prod_q;        // registered multiplier output
  // shared divide / root unit
  logic [63:0]       num_q, den_q, quo_q, rem_q;
  logic [63:0]       rbit_q;
  logic [6:0]        cnt_q;
  logic [63:0]       sx_q;
  logic              neg_q;
  logic              fin_q;          // final-phase flag: set for a last pair, cleared when cosine's second root starts
  out_item_t         out_q;
  logic              ovalid_q;

  // operands
  logic signed [16:0] dxy_s, sxy_s;
  logic [16:0]        dxy, sxy, ax, ay;
  always_comb begin
    dxy_s = y_q - x_q;
    sxy_s = x_q + y_q;
    dxy   = dxy_s[16] ? 17'(-dxy_s) : 17'(dxy_s);
    sxy   = sxy_s[16] ? 17'(-sxy_s) : 17'(sxy_s);
    ax    = x_q[16] ? 17'(-x_q) : 17'(x_q);
    ay    = y_q[16] ? 17'(-y_q) : 17'(y_q);
  end

  function automatic logic [31:0] sat_add(logic [31:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > 65'(U32Max)) ? U32Max : s[31:0];
  endfunction

  function automatic logic signed [63:0] fshift(logic signed [63:0] p);
    return p >>> FracBits;           // arithmetic shift is floor
  endfunction

  function automatic logic [15:0] clip(logic [63:0] v);
    return (v > 64'd32767) ? 16'h7FFF : v[15:0];
  endfunction

  // multiplier operand select: step 0 x*y, 1 x*x, 2 y*y; Euclidean |y-x|^2; S_COS_DEN sx*sy
  logic signed [32:0] ma, mb;
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state_q)
      S_COS_DEN: begin
        ma = 33'($signed({1'b0, sx_q[31:0]}));
        mb = 33'($signed({1'b0, quo_q[31:0]}));
      end
      default: begin
        if (metric_q == MET_EUCLIDEAN) begin
          ma = 33'($signed({1'b0, dxy}));
          mb = 33'($signed({1'b0, dxy}));
        end else begin
          case (mstep_q)
            2'd1: begin
              ma = 33'(x_q);
              mb = 33'(x_q);
            end
            2'd2: begin
              ma = 33'(y_q);
              mb = 33'(y_q);
            end
            default: begin
              ma = 33'(x_q);
              mb = 33'(y_q);
            end
          endcase
        end
      end
    endcase
  end

  logic signed [65:0] mfull;
  logic signed [63:0] mprod;
  logic [63:0]        mden;
  assign mfull = ma * mb;
  assign mprod = mfull[63:0];
  assign mden  = mprod >> FracBits;

  // square root step candidate and divide step
  logic [63:0] sq_t, dv_r;
  assign sq_t = quo_q + rbit_q;
  assign dv_r = {rem_q[62:0], num_q[63]};

  logic in_fire, out_fire, res_post;
  assign in_ch.ready  = (state_q == S_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = ovalid_q;
  assign out_ch.data  = out_q;
  assign out_fire     = ovalid_q && out_ch.ready;
  // final state may load the output register once it is free
  assign res_post     = (state_q == S_OUT) && (!ovalid_q || out_ch.ready);

  logic signed [63:0] dot_s, sim, dot_sum;
  always_comb begin
    dot_s   = 64'($signed(prim_q)) <<< FracBits;
    sim     = 64'(quo_q);
    dot_sum = 64'($signed(prim_q)) + fshift(prod_q);
  end

  out_item_t res_d;
  always_comb begin
    res_d = '0;
    unique case (metric_q) inside
      MET_MANHATTAN, MET_CHEBYSHEV, MET_CANBERRA:
        res_d.distance = clip(64'(prim_q));
      MET_EUCLIDEAN: begin
        res_d.distance  = clip(quo_q);
        res_d.saturated = quo_q > 64'd32767;
      end
      MET_BRAYCURT:
        if (nx_q != 0) res_d.distance = clip(quo_q);
      MET_COSINE:
        if (nx_q == 0 || ny_q == 0 || den_q == 0)
          res_d.distance = 16'(One);
        else if (quo_q >= One)
          res_d.distance = neg_q ? clip(One << 1) : '0;
        else
          res_d.distance = neg_q ? 16'(One + sim) : 16'(One - sim);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      metric_q <= MET_MANHATTAN;
      prim_q   <= '0;
      nx_q     <= '0;
      ny_q     <= '0;
      x_q      <= '0;
      y_q      <= '0;
      last_q   <= 1'b0;
      prod_q   <= '0;
      num_q    <= '0;
      den_q    <= '0;
      quo_q    <= '0;
      rem_q    <= '0;
      rbit_q   <= '0;
      cnt_q    <= '0;
      sx_q     <= '0;
      neg_q    <= 1'b0;
      ovalid_q <= 1'b0;
      mstep_q  <= '0;
      fin_q    <= 1'b0;
      out_q    <= '0;
    end else begin
      if (cfg_we_i) metric_q <= metric_e'(cfg_wdata_i);
      if (res_post) begin
        out_q    <= res_d;
        ovalid_q <= 1'b1;
      end else if (out_fire) begin
        ovalid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: if (in_fire) begin
          x_q     <= 17'(in_ch.data.x_value);
          y_q     <= 17'(in_ch.data.y_value);
          last_q  <= in_ch.data.last_element;
          mstep_q <= '0;
          state_q <= S_MUL;
        end
        S_MUL: begin
          prod_q <= mprod;
          if (metric_q == MET_CANBERRA) begin
            num_q   <= 64'(dxy) << FracBits;
            den_q   <= 64'(ax) + 64'(ay);
            rem_q   <= '0;
            quo_q   <= '0;
            cnt_q   <= 7'd64;
            state_q <= ((ax | ay) == 0) ? S_FIN : S_DIV;
          end else begin
            state_q <= S_ACC;
          end
        end
        S_ACC: begin
          unique case (metric_q)
            MET_MANHATTAN: prim_q <= sat_add(prim_q, 64'(dxy));
            MET_CHEBYSHEV: if (32'(dxy) > prim_q) prim_q <= 32'(dxy);
            MET_EUCLIDEAN: prim_q <= sat_add(prim_q, 64'(prod_q) >> FracBits);
            MET_BRAYCURT: begin
              prim_q <= sat_add(prim_q, 64'(dxy));
              nx_q   <= sat_add(nx_q, 64'(sxy));
            end
            // divide quotient of this pair
            MET_CANBERRA: prim_q <= sat_add(prim_q, quo_q);
            MET_COSINE: begin
              case (mstep_q)
                2'd0: begin
                  if (dot_sum > 64'sd2147483647)
                    prim_q <= 32'h7FFF_FFFF;
                  else if (dot_sum < -64'sd2147483648)
                    prim_q <= 32'h8000_0000;
                  else
                    prim_q <= dot_sum[31:0];
                end
                2'd1: nx_q <= sat_add(nx_q, 64'(fshift(prod_q)));
                default: ny_q <= sat_add(ny_q, 64'(fshift(prod_q)));
              endcase
            end
            default: ;
          endcase
          if (metric_q == MET_COSINE && mstep_q != 2'd2) begin
            mstep_q <= mstep_q + 2'd1;
            state_q <= S_MUL;
          end else begin
            state_q <= S_FIN;
          end
        end
        S_DIV: begin
          // restoring divide, one quotient bit per cycle
          if (dv_r >= den_q) begin
            rem_q <= dv_r - den_q;
            quo_q <= {quo_q[62:0], 1'b1};
          end else begin
            rem_q <= dv_r;
            quo_q <= {quo_q[62:0], 1'b0};
          end
          num_q <= {num_q[62:0], 1'b0};
          cnt_q <= cnt_q - 7'd1;
          if (cnt_q == 7'd1) begin
            if (metric_q == MET_CANBERRA && !fin_q) state_q <= S_ACC;
            else state_q <= S_OUT;
          end
        end
        S_SQRT: begin
          if (num_q >= sq_t) begin
            num_q <= num_q - sq_t;
            quo_q <= (quo_q >> 1) + rbit_q;
          end else begin
            quo_q <= quo_q >> 1;
          end
          rbit_q <= rbit_q >> 2;
          if (rbit_q[1:0] != 0 || rbit_q == 64'd1) begin
            state_q <= (metric_q == MET_COSINE) ? S_COS_SY : S_OUT;
          end
        end
        S_FIN: begin
          if (!last_q) begin
            state_q <= S_IDLE;
          end else begin
            fin_q <= 1'b1;
            rbit_q <= 64'd1 << 62;
            quo_q <= '0;
            rem_q <= '0;
            cnt_q <= 7'd64;
            unique case (metric_q)
              MET_EUCLIDEAN: begin
                num_q <= 64'(prim_q) << FracBits;
                state_q <= S_SQRT;
              end
              MET_COSINE: begin
                num_q <= 64'(nx_q) << FracBits;
                state_q <= (nx_q == 0 || ny_q == 0) ? S_OUT : S_SQRT;
              end
              MET_BRAYCURT: begin
                num_q <= 64'(prim_q) << FracBits;
                den_q <= 64'(nx_q);
                state_q <= (nx_q == 0) ? S_OUT : S_DIV;
              end
              default: state_q <= S_OUT;
            endcase
          end
        end
        S_COS_SY: begin
          if (fin_q) begin
            sx_q    <= quo_q;
            fin_q   <= 1'b0;
            num_q   <= 64'(ny_q) << FracBits;
            quo_q   <= '0;
            rbit_q  <= 64'd1 << 62;
            state_q <= S_SQRT;
          end else begin
            state_q <= S_COS_DEN;
          end
        end
        S_COS_DEN: begin
          den_q   <= mden;
          neg_q   <= prim_q[31];
          num_q   <= prim_q[31] ? 64'(-dot_s) : 64'(dot_s);
          quo_q   <= '0;
          rem_q   <= '0;
          cnt_q   <= 7'd64;
          fin_q   <= 1'b1;
          state_q <= (mden == 0) ? S_OUT : S_DIV;
        end
        S_OUT: begin
          if (res_post) begin
            prim_q  <= '0;
            nx_q    <= '0;
            ny_q    <= '0;
            fin_q   <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // result holds while the receiver stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && !out_ch.ready |=> ovalid_q)
    else $error("result dropped under stall");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == S_MUL)
    else $error("accepted pair not started");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_post |=> ovalid_q && prim_q == '0)
    else $error("result not posted or sums not cleared");
endmodule

FILE: tb/sv/vde_distance_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vde_distance_checker: distance predictor and result scoreboard
// Watches the pair and distance channels and the metric register, folds
// every accepted pair into its own accumulators and compares each
// distance transfer against the oldest predicted one.
// ----------------------------------------------------------------------------
module vde_distance_checker
  import vde_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_wdata_i,
  vde_in_if          in_ch,
  vde_out_if         out_ch,
  output int         fail_cnt_o,
  output int         pending_o
);

  localparam longint unsigned SumMax  = 64'hFFFF_FFFF;
  localparam longint          DistMax = 32767;
  localparam longint          One     = longint'(1) << FracBits;

  metric_e     metric_q;
  logic [31:0] diff_sum, x_norm, y_norm;
  out_item_t   dist_q[$];

  function automatic logic [31:0] sat_add(logic [31:0] a, longint unsigned b);
    longint unsigned s;
    s = longint'(a) + b;
    return (s > SumMax) ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [15:0] clip16(longint unsigned v);
    return (v > DistMax) ? 16'(DistMax) : v[15:0];
  endfunction

  function automatic logic [15:0] cos_expect();
    longint dot, sim, den;
    longint unsigned sx, sy;
    if (x_norm == 0 || y_norm == 0) return 16'(One);
    sx = int_sqrt(longint'(x_norm) << FracBits);
    sy = int_sqrt(longint'(y_norm) << FracBits);
    if (sx == 0 || sy == 0) return 16'(One);
    den = longint'((sx * sy) >> FracBits);
    if (den == 0) return 16'(One);
    dot = longint'($signed(diff_sum));
    sim = (dot * One) / den;
    if (sim > One) sim = One;
    if (sim < -One) sim = -One;
    return clip16(longint'(One - sim));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    longint xs, ys, d, den, s;
    out_item_t exp_r, got_r;
    int errs;
    if (!rst_ni) begin
      metric_q   <= MET_MANHATTAN;
      diff_sum   = 0;
      x_norm     = 0;
      y_norm     = 0;
      fail_cnt_o <= 0;
      pending_o  <= 0;
      dist_q.delete();
    end else begin
      if (cfg_we_i) metric_q <= metric_e'(cfg_wdata_i);
      if (in_ch.valid && in_ch.ready) begin
        xs = longint'(in_ch.data.x_value);
        ys = longint'(in_ch.data.y_value);
        d  = ys - xs;
        if (d < 0) d = -d;
        case (metric_q)
          MET_MANHATTAN: diff_sum = sat_add(diff_sum, d);
          MET_CHEBYSHEV: if (d > longint'(diff_sum)) diff_sum = d[31:0];
          MET_EUCLIDEAN: diff_sum = sat_add(diff_sum, (d * d) >> FracBits);
          MET_COSINE: begin
            // dot product floors negative products and clamps to int32
            s = longint'($signed(diff_sum)) + ((xs * ys) >>> FracBits);
            if (s > 64'sh7FFF_FFFF) s = 64'sh7FFF_FFFF;
            if (s < -64'sh8000_0000) s = -64'sh8000_0000;
            diff_sum = s[31:0];
            x_norm = sat_add(x_norm, (xs * xs) >>> FracBits);
            y_norm = sat_add(y_norm, (ys * ys) >>> FracBits);
          end
          MET_BRAYCURT: begin
            diff_sum = sat_add(diff_sum, d);
            s = xs + ys;
            x_norm = sat_add(x_norm, (s < 0) ? -s : s);
          end
          MET_CANBERRA: begin
            den = ((xs < 0) ? -xs : xs) + ((ys < 0) ? -ys : ys);
            if (den != 0) diff_sum = sat_add(diff_sum, (d << FracBits) / den);
          end
          default: ;
        endcase
        if (in_ch.data.last_element) begin
          exp_r = '0;
          case (metric_q)
            MET_MANHATTAN, MET_CHEBYSHEV, MET_CANBERRA:
              exp_r.distance = clip16(diff_sum);
            MET_EUCLIDEAN: begin
              s = longint'(int_sqrt(longint'(diff_sum) << FracBits));
              if (s > DistMax) begin
                exp_r.distance  = 16'(DistMax);
                exp_r.saturated = 1'b1;
              end else begin
                exp_r.distance = s[15:0];
              end
            end
            MET_COSINE: exp_r.distance = cos_expect();
            MET_BRAYCURT:
              if (x_norm != 0)
                exp_r.distance = clip16((longint'(diff_sum) << FracBits) / x_norm);
            default: ;
          endcase
          dist_q.push_back(exp_r);
          diff_sum = 0;
          x_norm   = 0;
          y_norm   = 0;
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        errs  = 0;
        got_r = out_ch.data;
        if (dist_q.size() == 0) begin
          $error("unexpected distance transfer: distance=%0d saturated=%0b",
                 got_r.distance, got_r.saturated);
          errs++;
        end else begin
          exp_r = dist_q.pop_front();
          if (got_r.distance !== exp_r.distance) begin
            $error("distance: expected %0d, actual %0d",
                   exp_r.distance, got_r.distance);
            errs++;
          end
          if (got_r.saturated !== exp_r.saturated) begin
            $error("saturated: expected %0b, actual %0b",
                   exp_r.saturated, got_r.saturated);
            errs++;
          end
        end
        fail_cnt_o <= fail_cnt_o + errs;
      end
      pending_o <= dist_q.size();
    end
  end

endmodule

FILE: tb/sv/tb_vector_distance_engine_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_vector_distance_engine_top: testbench for the vector distance engine
// Runs directed corner vectors and random vectors under every metric
// setting with random gaps on both channels; the checker compares.
// ----------------------------------------------------------------------------
module tb_vector_distance_engine_top;
  import vde_pkg::*;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [2:0] cfg_wdata_i;
  int         fail_cnt;
  int         pending;

  vde_in_if  in_ch ();
  vde_out_if out_ch ();

  vector_distance_engine_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  vde_distance_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

  // gap before each transfer; a burst draw (one in four) takes no gap at all
  function automatic int draw_gap(bit burst);
    return burst ? 0 : $urandom_range(0, 11);
  endfunction

  task automatic send_pair(logic signed [15:0] x, logic signed [15:0] y, logic last);
    int gap;
    gap = draw_gap($urandom_range(0, 3) == 0);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid             <= 1'b1;
    in_ch.data.x_value      <= x;
    in_ch.data.y_value      <= y;
    in_ch.data.last_element <= last;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_metric(metric_e m);
    in_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (300) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [15:0] rand_elem();
    case ($urandom_range(0, 5))
      0:       return 16'($urandom);
      1:       return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      2:       return 16'($urandom_range(0, 8)) - 16'd4;
      default: return 16'($urandom_range(0, 4096)) - 16'd2048;
    endcase
  endfunction

  // receiver side: random stalls on the distance channel
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      gap = draw_gap($urandom_range(0, 3) == 0);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid) @(posedge clk_i);
    end
  end

  initial begin
    metric_e order[$];
    int len;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = MET_MANHATTAN;
    rst_ni       = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed corners, reset metric first
    send_pair(-16'sd32768, 16'sd32767, 1'b1);
    send_pair(16'sd3, -16'sd2, 1'b1);
    set_metric(MET_CHEBYSHEV);
    send_pair(16'sd1, 16'sd9, 1'b0);
    send_pair(16'sd32767, -16'sd32768, 1'b1);
    set_metric(MET_EUCLIDEAN);
    send_pair(-16'sd32768, 16'sd32767, 1'b1);
    send_pair(16'sd0, 16'sd0, 1'b1);
    send_pair(16'sd300, 16'sd0, 1'b1);
    set_metric(MET_COSINE);
    send_pair(16'sd0, 16'sd0, 1'b1);
    send_pair(16'sd512, -16'sd512, 1'b1);
    send_pair(-16'sd32768, -16'sd32768, 1'b0);
    send_pair(16'sd32767, 16'sd32767, 1'b1);
    send_pair(16'sd1, 16'sd1, 1'b1);
    set_metric(MET_BRAYCURT);
    send_pair(16'sd5, -16'sd5, 1'b1);
    send_pair(16'sd100, 16'sd50, 1'b1);
    set_metric(MET_CANBERRA);
    send_pair(16'sd0, 16'sd0, 1'b0);
    send_pair(16'sd3, 16'sd1, 1'b1);
    send_pair(-16'sd32768, 16'sd32767, 1'b1);
    set_metric(MET_UNUSED6);
    send_pair(16'sd7, 16'sd1, 1'b1);
    set_metric(MET_UNUSED7);
    send_pair(16'sd7, 16'sd1, 1'b1);
    // metric switched mid-vector: sums carry over
    set_metric(MET_MANHATTAN);
    send_pair(16'sd10, 16'sd20, 1'b0);
    set_metric(MET_BRAYCURT);
    send_pair(16'sd1, 16'sd2, 1'b1);

    for (int m = 0; m < 8; m++) order.push_back(metric_e'(m));
    for (int m = 0; m < 8; m++) order.push_back(metric_e'($urandom_range(0, 7)));
    foreach (order[i]) begin
      set_metric(order[i]);
      for (int n = 0; n < 86; ) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 6);
        for (int k = 1; k <= len; k++) begin
          send_pair(rand_elem(), rand_elem(), k == len);
          n++;
        end
      end
    end

    in_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (300) @(negedge clk_i);
    if (fail_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
